@@ sv/polyline_stroke_quads_macros.svh @@
// ----------------------------------------------------------------------------
// polyline_stroke_quads assertion macros
// Shorthands for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_STROKE_QUADS_MACROS_SVH
`define POLYLINE_STROKE_QUADS_MACROS_SVH

// same-cycle implication
`define PSQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/psq_pkg.sv @@
// ----------------------------------------------------------------------------
// psq_pkg
// Shared types, constants and the corner offset vector selection.
// ----------------------------------------------------------------------------
package psq_pkg;

    localparam int NORM_W      = 16;
    localparam int VEC_W       = 17;
    localparam int HW_W        = 16;
    localparam logic [HW_W-1:0] HW_RESET = 16'd128;
    localparam int QUEUE_DEPTH = 2;

    // front normal unit sizes
    localparam int F_SQ_IW = 62;
    localparam int F_DIV_DW = 46;
    localparam int F_DIV_VW = 32;
    localparam int F_DIV_QW = 16;

    // back offset unit sizes
    localparam int B_SQ_IW = 52;
    localparam int B_DIV_DW = 44;
    localparam int B_DIV_VW = 27;
    localparam int B_DIV_QW = 17;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
    } vec_t;

    typedef struct packed {
        vec_t s1;
        vec_t s2;
        logic fin;
    } job_t;

    function automatic vec_t sum_vec(
        input logic signed [NORM_W-1:0] ax,
        input logic signed [NORM_W-1:0] ay,
        input logic                     pair,
        input logic signed [NORM_W-1:0] bx,
        input logic signed [NORM_W-1:0] by
    );
        vec_t v;
        v.x = VEC_W'(ax);
        v.y = VEC_W'(ay);
        if (pair) begin
            if ((ax == '0 && ay == '0) || (bx == '0 && by == '0)) begin
                v.x = '0;
                v.y = '0;
            end else begin
                v.x = VEC_W'(ax) + VEC_W'(bx);
                v.y = VEC_W'(ay) + VEC_W'(by);
            end
        end
        return v;
    endfunction

endpackage

@@ sv/psq_ifs.sv @@
// ----------------------------------------------------------------------------
// psq interfaces
// Point, quad and half width channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface psq_point_if #(parameter int COORD_WIDTH = 24);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface psq_quad_if #(parameter int COORD_WIDTH = 24);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] corner0_x;
    logic signed [COORD_WIDTH-1:0] corner0_y;
    logic signed [COORD_WIDTH-1:0] corner1_x;
    logic signed [COORD_WIDTH-1:0] corner1_y;
    logic signed [COORD_WIDTH-1:0] corner2_x;
    logic signed [COORD_WIDTH-1:0] corner2_y;
    logic signed [COORD_WIDTH-1:0] corner3_x;
    logic signed [COORD_WIDTH-1:0] corner3_y;
    logic                          final_quad;
    logic                          degenerate;
    logic                          saturated;

    modport source (output valid, corner0_x, corner0_y, corner1_x, corner1_y,
                    corner2_x, corner2_y, corner3_x, corner3_y, final_quad,
                    degenerate, saturated, input ready);
    modport sink (input valid, corner0_x, corner0_y, corner1_x, corner1_y,
                  corner2_x, corner2_y, corner3_x, corner3_y, final_quad,
                  degenerate, saturated, output ready);
endinterface

interface psq_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] half_width;

    modport source (output valid, half_width, input ready);
    modport sink (input valid, half_width, output ready);
endinterface

@@ sv/polyline_stroke_quads.sv @@
// ----------------------------------------------------------------------------
// polyline_stroke_quads
// Stroke extrusion of a polyline into one quad per segment.
// ----------------------------------------------------------------------------
// Points enter on the point channel, one beat per point, last_point on the
// final point of a line. Quads leave on the quad channel, one beat each; a
// segment's quad leaves once the next point (or the end of line) is known,
// so a last point after two or more earlier ones yields two quads.
// The cfg channel writes half_width (unsigned Q8.8); it is always ready and
// should only be written while no point is in flight.
// The front takes one point at a time and forms the normal with one square
// root unit and one divider, after shifting a segment's components right
// until both fit in 20 bits. The back computes the two offsets of each quad
// through its own root and divide unit and takes a new job only once the
// last one's quad is in the output register.
// A two-entry job queue parts front and back, and an output register holds
// a finished quad, so a stalled receiver backs up the back first, then the
// queue, then the point channel.
// Reset clears the line state and sets half_width to 0.5.
// ----------------------------------------------------------------------------
`include "polyline_stroke_quads_macros.svh"

module polyline_stroke_quads #(
    parameter int COORD_WIDTH = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    psq_point_if.sink   point,
    psq_quad_if.source  quad,
    psq_cfg_if.sink     cfg
);
    import psq_pkg::*;

    localparam int PTS_W = 4 * COORD_WIDTH;
    localparam int QW    = PTS_W + $bits(job_t);

    logic [HW_W-1:0]  hw_reg;
    logic             q_push_valid, q_push_ready;
    logic [PTS_W-1:0] push_pts;
    job_t             push_job;
    logic             q_pop_valid, q_pop_ready;
    logic [QW-1:0]    pop_data;
    job_t             pop_job;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            hw_reg <= HW_RESET;
        end
        else if (cfg.valid)
        begin
            hw_reg <= cfg.half_width;
        end
    end

    psq_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .point      (point),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_pts   (push_pts),
        .push_job   (push_job)
    );

    psq_queue #(.W(QW)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  ({push_pts, push_job}),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_job = pop_data[$bits(job_t)-1:0];

    psq_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .half_width (hw_reg),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_pts    (pop_data[QW-1 -: PTS_W]),
        .pop_job    (pop_job),
        .quad       (quad)
    );

    `PSQ_ASSERT_NEXT(a_one_point_at_a_time, point.valid && point.ready, !point.ready,
        "front took a second point before finishing the first")
    `PSQ_ASSERT_NOW(a_pop_needs_room, q_pop_valid && q_pop_ready, !quad.valid || quad.ready,
        "job retired while the output register was still full")
endmodule

@@ sv/psq_isqrt.sv @@
// ----------------------------------------------------------------------------
// psq_isqrt
// Iterative floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module psq_isqrt #(
    parameter int IW = 62
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [IW-1:0]   radicand,
    output logic            done,
    output logic [IW/2-1:0] root
);
    localparam int RW  = IW / 2;
    localparam int CNW = $clog2(RW + 1);

    logic           busy_reg;
    logic           done_reg;
    logic [CNW-1:0] cnt_reg;
    logic [IW-1:0]  sh_reg;
    logic [RW+1:0]  rem_reg;
    logic [RW-1:0]  root_reg;
    logic [RW+3:0]  cur;
    logic [RW+3:0]  trial;
    logic [RW+3:0]  diff;
    logic           ge;

    assign cur   = {rem_reg, sh_reg[IW-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign diff  = cur - trial;
    assign ge    = cur >= trial;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNW'(RW);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != CNW'(1);
            done_reg <= cnt_reg == CNW'(1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (start)
        begin
            sh_reg   <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg   <= {sh_reg[IW-3:0], 2'b00};
            rem_reg  <= ge ? diff[RW+1:0] : cur[RW+1:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

@@ sv/psq_div.sv @@
// ----------------------------------------------------------------------------
// psq_div
// Restoring divider, one quotient bit per cycle; quotient must fit QW bits.
// ----------------------------------------------------------------------------
module psq_div #(
    parameter int DW = 46,
    parameter int VW = 32,
    parameter int QW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [QW-1:0] quotient
);
    localparam int CNW = $clog2(QW + 1);

    logic           busy_reg;
    logic           done_reg;
    logic [CNW-1:0] cnt_reg;
    logic [VW-1:0]  rem_reg;
    logic [QW-1:0]  dsh_reg;
    logic [VW-1:0]  v_reg;
    logic [QW-1:0]  q_reg;
    logic [VW:0]    cur;
    logic [VW:0]    diff;
    logic           ge;

    assign cur  = {rem_reg, dsh_reg[QW-1]};
    assign diff = cur - {1'b0, v_reg};
    assign ge   = cur >= {1'b0, v_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNW'(QW);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != CNW'(1);
            done_reg <= cnt_reg == CNW'(1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (start)
        begin
            rem_reg <= VW'(dividend >> QW);
            dsh_reg <= dividend[QW-1:0];
            v_reg   <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[VW-1:0] : cur[VW-1:0];
            dsh_reg <= {dsh_reg[QW-2:0], 1'b0};
            q_reg   <= {q_reg[QW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

@@ sv/psq_front.sv @@
// ----------------------------------------------------------------------------
// psq_front
// Accepts points, forms segment normals and queues quad jobs.
// ----------------------------------------------------------------------------
module psq_front #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    psq_point_if.sink                  point,
    output logic                       push_valid,
    input  logic                       push_ready,
    output logic [4*COORD_WIDTH-1:0]   push_pts,
    output psq_pkg::job_t              push_job
);
    import psq_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int MW = CW + 1;
    localparam int UW = (MW > 21) ? MW : 21;

    localparam logic [3:0] F_IDLE  = 4'd0;
    localparam logic [3:0] F_LOAD  = 4'd1;
    localparam logic [3:0] F_SHIFT = 4'd2;
    localparam logic [3:0] F_SQ    = 4'd3;
    localparam logic [3:0] F_SUM   = 4'd4;
    localparam logic [3:0] F_ROOT  = 4'd5;
    localparam logic [3:0] F_GOX   = 4'd6;
    localparam logic [3:0] F_DIVX  = 4'd7;
    localparam logic [3:0] F_GOY   = 4'd8;
    localparam logic [3:0] F_DIVY  = 4'd9;
    localparam logic [3:0] F_PUSH1 = 4'd10;
    localparam logic [3:0] F_PUSH2 = 4'd11;

    logic [3:0] state_reg, state_next;

    logic signed [CW-1:0]     px_reg, py_reg;
    logic                     last_reg;
    logic signed [CW-1:0]     older_x_reg, older_y_reg, newer_x_reg, newer_y_reg;
    logic signed [NORM_W-1:0] seg_x_reg, seg_y_reg, before_x_reg, before_y_reg;
    logic signed [NORM_W-1:0] nx_reg, ny_reg;
    logic [1:0]               seen_reg;
    logic                     has_before_reg;
    logic [UW-1:0]            ua_reg, ub_reg;
    logic                     neg_a_reg, neg_b_reg;
    logic [39:0]              sqa_reg, sqb_reg;
    logic [F_SQ_IW/2-1:0]     r_reg;

    logic signed [MW-1:0] dx, dy;
    logic [MW-1:0]        mag_a, mag_b;
    logic                 too_big, is_zero;
    logic                 sq_start, sq_done;
    logic [F_SQ_IW-1:0]   sq_in;
    logic [F_SQ_IW/2-1:0] sq_root;
    logic                 div_start, div_done;
    logic [F_DIV_DW-1:0]  div_in;
    logic [F_DIV_QW-1:0]  div_q;
    logic [19:0]          div_mag;
    logic signed [NORM_W-1:0] div_norm;
    logic                 advance1, advance2;

    assign dx      = MW'(px_reg) - MW'(newer_x_reg);
    assign dy      = MW'(py_reg) - MW'(newer_y_reg);
    assign mag_a   = dy[MW-1] ? MW'(-dy) : MW'(dy);
    assign mag_b   = dx[MW-1] ? MW'(-dx) : MW'(dx);
    assign too_big = ((ua_reg >> 20) != '0) || ((ub_reg >> 20) != '0);
    assign is_zero = (ua_reg == '0) && (ub_reg == '0);

    assign sq_start = state_reg == F_SUM;
    assign sq_in    = {1'b0, {1'b0, sqa_reg} + {1'b0, sqb_reg}, 20'b0};

    assign div_start = (state_reg == F_GOX) || (state_reg == F_GOY);
    assign div_mag   = (state_reg == F_GOX) ? ua_reg[19:0] : ub_reg[19:0];
    assign div_in    = F_DIV_DW'({div_mag, 25'b0}) + F_DIV_DW'(r_reg);
    assign div_norm  = ((state_reg == F_DIVX) ? neg_a_reg : neg_b_reg)
                     ? -$signed(div_q) : $signed(div_q);

    psq_isqrt #(.IW(F_SQ_IW)) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    psq_div #(.DW(F_DIV_DW), .VW(F_DIV_VW), .QW(F_DIV_QW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in),
        .divisor  ({r_reg, 1'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    assign point.ready = state_reg == F_IDLE;
    assign push_valid  = ((state_reg == F_PUSH1) && (seen_reg == 2'd2))
                       || (state_reg == F_PUSH2);
    assign advance1    = (state_reg == F_PUSH1) && ((seen_reg != 2'd2) || push_ready);
    assign advance2    = (state_reg == F_PUSH2) && push_ready;
    assign push_pts    = {older_x_reg, older_y_reg, newer_x_reg, newer_y_reg};

    always_comb begin
        push_job.s1  = sum_vec(seg_x_reg, seg_y_reg, has_before_reg, before_x_reg,
                               before_y_reg);
        push_job.s2  = sum_vec(seg_x_reg, seg_y_reg, 1'b1, nx_reg, ny_reg);
        push_job.fin = 1'b0;
        if (state_reg == F_PUSH2)
        begin
            push_job.s2  = sum_vec(seg_x_reg, seg_y_reg, 1'b0, '0, '0);
            push_job.fin = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (point.valid) state_next = F_LOAD;
            F_LOAD:  state_next = (seen_reg == 2'd0) ? F_IDLE : F_SHIFT;
            F_SHIFT:
            begin
                if (!too_big) state_next = is_zero ? F_PUSH1 : F_SQ;
            end
            F_SQ:    state_next = F_SUM;
            F_SUM:   state_next = F_ROOT;
            F_ROOT:  if (sq_done) state_next = F_GOX;
            F_GOX:   state_next = F_DIVX;
            F_DIVX:  if (div_done) state_next = F_GOY;
            F_GOY:   state_next = F_DIVY;
            F_DIVY:  if (div_done) state_next = F_PUSH1;
            F_PUSH1: if (advance1) state_next = last_reg ? F_PUSH2 : F_IDLE;
            F_PUSH2: if (advance2) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            older_x_reg    <= '0;
            older_y_reg    <= '0;
            newer_x_reg    <= '0;
            newer_y_reg    <= '0;
            seg_x_reg      <= '0;
            seg_y_reg      <= '0;
            before_x_reg   <= '0;
            before_y_reg   <= '0;
            seen_reg       <= '0;
            has_before_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == F_LOAD) && (seen_reg == 2'd0))
            begin
                newer_x_reg <= last_reg ? '0 : px_reg;
                newer_y_reg <= last_reg ? '0 : py_reg;
                seen_reg    <= last_reg ? 2'd0 : 2'd1;
            end
            if (advance1)
            begin
                if (seen_reg == 2'd2)
                begin
                    before_x_reg   <= seg_x_reg;
                    before_y_reg   <= seg_y_reg;
                    has_before_reg <= 1'b1;
                end
                else
                begin
                    has_before_reg <= 1'b0;
                end
                older_x_reg <= newer_x_reg;
                older_y_reg <= newer_y_reg;
                newer_x_reg <= px_reg;
                newer_y_reg <= py_reg;
                seg_x_reg   <= nx_reg;
                seg_y_reg   <= ny_reg;
                seen_reg    <= 2'd2;
            end
            if (advance2)
            begin
                older_x_reg    <= '0;
                older_y_reg    <= '0;
                newer_x_reg    <= '0;
                newer_y_reg    <= '0;
                seg_x_reg      <= '0;
                seg_y_reg      <= '0;
                before_x_reg   <= '0;
                before_y_reg   <= '0;
                seen_reg       <= '0;
                has_before_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (point.valid && point.ready)
        begin
            px_reg   <= point.point_x;
            py_reg   <= point.point_y;
            last_reg <= point.last_point;
        end
        if (state_reg == F_LOAD)
        begin
            ua_reg    <= UW'(mag_a);
            ub_reg    <= UW'(mag_b);
            neg_a_reg <= dy[MW-1];
            neg_b_reg <= !dx[MW-1] && (dx != '0);
        end
        if (state_reg == F_SHIFT)
        begin
            if (too_big)
            begin
                ua_reg <= ua_reg >> 1;
                ub_reg <= ub_reg >> 1;
            end
            else if (is_zero)
            begin
                nx_reg <= '0;
                ny_reg <= '0;
            end
        end
        if (state_reg == F_SQ)
        begin
            sqa_reg <= ua_reg[19:0] * ua_reg[19:0];
            sqb_reg <= ub_reg[19:0] * ub_reg[19:0];
        end
        if ((state_reg == F_ROOT) && sq_done) r_reg <= sq_root;
        if ((state_reg == F_DIVX) && div_done) nx_reg <= div_norm;
        if ((state_reg == F_DIVY) && div_done) ny_reg <= div_norm;
    end
endmodule

@@ sv/psq_queue.sv @@
// ----------------------------------------------------------------------------
// psq_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module psq_queue #(
    parameter int W = 165
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);
    import psq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]   entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_reg, rd_reg;
    logic [CNW-1:0] cnt_reg;
    logic           do_push, do_pop;

    assign push_ready = cnt_reg != CNW'(QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = entry_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push) wr_reg <= wr_reg + 1'b1;
            if (do_pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + CNW'(do_push) - CNW'(do_pop);
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) entry_reg[wr_reg] <= push_data;
    end
endmodule

@@ sv/psq_back.sv @@
// ----------------------------------------------------------------------------
// psq_back
// Turns quad jobs into scaled offsets and saturated corners.
// ----------------------------------------------------------------------------
module psq_back #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [15:0]              half_width,
    input  logic                     pop_valid,
    output logic                     pop_ready,
    input  logic [4*COORD_WIDTH-1:0] pop_pts,
    input  psq_pkg::job_t            pop_job,
    psq_quad_if.source               quad
);
    import psq_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int OW = B_DIV_QW + 1;
    localparam int SW = ((CW > OW) ? CW : OW) + 1;
    localparam logic signed [SW-1:0] HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] LO = ~HI;

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_PREP = 4'd1;
    localparam logic [3:0] B_SQ   = 4'd2;
    localparam logic [3:0] B_SUM  = 4'd3;
    localparam logic [3:0] B_ROOT = 4'd4;
    localparam logic [3:0] B_GOX  = 4'd5;
    localparam logic [3:0] B_DIVX = 4'd6;
    localparam logic [3:0] B_GOY  = 4'd7;
    localparam logic [3:0] B_DIVY = 4'd8;
    localparam logic [3:0] B_EMIT = 4'd9;

    function automatic logic [CW:0] clamp_add(
        input logic signed [CW-1:0] v,
        input logic signed [OW-1:0] o
    );
        logic signed [SW-1:0] c;
        c = SW'(v) + SW'(o);
        if (c > HI) return {1'b1, HI[CW-1:0]};
        if (c < LO) return {1'b1, LO[CW-1:0]};
        return {1'b0, c[CW-1:0]};
    endfunction

    logic [3:0]            state_reg, state_next;
    logic                  phase_reg;
    logic                  deg_reg;
    logic [15:0]           ux_reg, uy_reg;
    logic                  negx_reg, negy_reg;
    logic [30:0]           sqa_reg, sqb_reg;
    logic [31:0]           mx_reg, my_reg;
    logic [B_SQ_IW/2-1:0]  r_reg;
    logic signed [OW-1:0]  ox1_reg, oy1_reg, ox2_reg, oy2_reg;

    logic                       out_valid_reg;
    logic signed [CW-1:0]       c0x_reg, c0y_reg, c1x_reg, c1y_reg;
    logic signed [CW-1:0]       c2x_reg, c2y_reg, c3x_reg, c3y_reg;
    logic                       fin_reg, odeg_reg, sat_reg;

    vec_t                  vsel;
    logic [15:0]           magx, magy;
    logic                  vzero;
    logic                  sq_start, sq_done;
    logic [B_SQ_IW-1:0]    sq_in;
    logic [B_SQ_IW/2-1:0]  sq_root;
    logic                  div_start, div_done;
    logic [B_DIV_DW-1:0]   div_in;
    logic [B_DIV_QW-1:0]   div_q;
    logic signed [OW-1:0]  div_off;
    logic                  room, load;
    logic signed [CW-1:0]  x0, y0, x1, y1;
    logic [CW:0]           k0x, k0y, k1x, k1y, k2x, k2y, k3x, k3y;

    assign vsel  = phase_reg ? pop_job.s2 : pop_job.s1;
    assign magx  = vsel.x[VEC_W-1] ? 16'(-vsel.x) : 16'(vsel.x);
    assign magy  = vsel.y[VEC_W-1] ? 16'(-vsel.y) : 16'(vsel.y);
    assign vzero = (vsel.x == '0) && (vsel.y == '0);

    assign sq_start  = state_reg == B_SUM;
    assign sq_in     = {{1'b0, sqa_reg} + {1'b0, sqb_reg}, 20'b0};
    assign div_start = (state_reg == B_GOX) || (state_reg == B_GOY);
    assign div_in    = B_DIV_DW'({(state_reg == B_GOX) ? mx_reg : my_reg, 11'b0})
                     + B_DIV_DW'(r_reg);
    assign div_off   = ((state_reg == B_DIVX) ? negx_reg : negy_reg)
                     ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    psq_isqrt #(.IW(B_SQ_IW)) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    psq_div #(.DW(B_DIV_DW), .VW(B_DIV_VW), .QW(B_DIV_QW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_in),
        .divisor  ({r_reg, 1'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    assign x0 = pop_pts[4*CW-1 -: CW];
    assign y0 = pop_pts[3*CW-1 -: CW];
    assign x1 = pop_pts[2*CW-1 -: CW];
    assign y1 = pop_pts[CW-1 -: CW];

    assign k0x = clamp_add(x0, ox1_reg);
    assign k0y = clamp_add(y0, oy1_reg);
    assign k1x = clamp_add(x0, -ox1_reg);
    assign k1y = clamp_add(y0, -oy1_reg);
    assign k2x = clamp_add(x1, -ox2_reg);
    assign k2y = clamp_add(y1, -oy2_reg);
    assign k3x = clamp_add(x1, ox2_reg);
    assign k3y = clamp_add(y1, oy2_reg);

    assign room      = !out_valid_reg || quad.ready;
    assign load      = (state_reg == B_EMIT) && room;
    assign pop_ready = load;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (pop_valid) state_next = B_PREP;
            B_PREP:
            begin
                if (!vzero) state_next = B_SQ;
                else state_next = phase_reg ? B_EMIT : B_PREP;
            end
            B_SQ:   state_next = B_SUM;
            B_SUM:  state_next = B_ROOT;
            B_ROOT: if (sq_done) state_next = B_GOX;
            B_GOX:  state_next = B_DIVX;
            B_DIVX: if (div_done) state_next = B_GOY;
            B_GOY:  state_next = B_DIVY;
            B_DIVY: if (div_done) state_next = phase_reg ? B_EMIT : B_PREP;
            B_EMIT: if (room) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_IDLE) phase_reg <= 1'b0;
            if ((state_reg == B_PREP) && vzero) phase_reg <= 1'b1;
            if ((state_reg == B_DIVY) && div_done) phase_reg <= 1'b1;
            if (load) out_valid_reg <= 1'b1;
            else if (quad.ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (state_reg == B_IDLE) deg_reg <= 1'b0;
        if (state_reg == B_PREP)
        begin
            ux_reg   <= magx;
            uy_reg   <= magy;
            negx_reg <= vsel.x[VEC_W-1];
            negy_reg <= vsel.y[VEC_W-1];
            if (vzero)
            begin
                deg_reg <= 1'b1;
                if (phase_reg)
                begin
                    ox2_reg <= '0;
                    oy2_reg <= '0;
                end
                else
                begin
                    ox1_reg <= '0;
                    oy1_reg <= '0;
                end
            end
        end
        if (state_reg == B_SQ)
        begin
            sqa_reg <= 31'(ux_reg * ux_reg);
            sqb_reg <= 31'(uy_reg * uy_reg);
            mx_reg  <= ux_reg * half_width;
            my_reg  <= uy_reg * half_width;
        end
        if ((state_reg == B_ROOT) && sq_done) r_reg <= sq_root;
        if ((state_reg == B_DIVX) && div_done)
        begin
            if (phase_reg) ox2_reg <= div_off;
            else ox1_reg <= div_off;
        end
        if ((state_reg == B_DIVY) && div_done)
        begin
            if (phase_reg) oy2_reg <= div_off;
            else oy1_reg <= div_off;
        end
        if (load)
        begin
            c0x_reg  <= k0x[CW-1:0];
            c0y_reg  <= k0y[CW-1:0];
            c1x_reg  <= k1x[CW-1:0];
            c1y_reg  <= k1y[CW-1:0];
            c2x_reg  <= k2x[CW-1:0];
            c2y_reg  <= k2y[CW-1:0];
            c3x_reg  <= k3x[CW-1:0];
            c3y_reg  <= k3y[CW-1:0];
            fin_reg  <= pop_job.fin;
            odeg_reg <= deg_reg;
            sat_reg  <= k0x[CW] | k0y[CW] | k1x[CW] | k1y[CW]
                      | k2x[CW] | k2y[CW] | k3x[CW] | k3y[CW];
        end
    end

    assign quad.valid      = out_valid_reg;
    assign quad.corner0_x  = c0x_reg;
    assign quad.corner0_y  = c0y_reg;
    assign quad.corner1_x  = c1x_reg;
    assign quad.corner1_y  = c1y_reg;
    assign quad.corner2_x  = c2x_reg;
    assign quad.corner2_y  = c2y_reg;
    assign quad.corner3_x  = c3x_reg;
    assign quad.corner3_y  = c3y_reg;
    assign quad.final_quad = fin_reg;
    assign quad.degenerate = odeg_reg;
    assign quad.saturated  = sat_reg;
endmodule

@@ sim/tb_polyline_stroke_quads.sv @@
// ----------------------------------------------------------------------------
// tb_polyline_stroke_quads
// Self-checking testbench for the polyline stroke quad extruder.
// ----------------------------------------------------------------------------
// Drives polylines of points into the block and predicts every quad in a
// scoreboard that keeps its own copy of the line state and half width. The
// run starts with hand-picked lines: extreme coordinates, zero-length
// segments, cancelling normals, single point and two point lines. Random
// lines follow, under several half widths and idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_polyline_stroke_quads;
    import psq_pkg::*;

    localparam int CW = 24;
    localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam int END_WAIT = 400;

    typedef struct packed {
        logic signed [CW-1:0] c0x;
        logic signed [CW-1:0] c0y;
        logic signed [CW-1:0] c1x;
        logic signed [CW-1:0] c1y;
        logic signed [CW-1:0] c2x;
        logic signed [CW-1:0] c2y;
        logic signed [CW-1:0] c3x;
        logic signed [CW-1:0] c3y;
        logic                 fin;
        logic                 deg;
        logic                 sat;
    } quad_t;

    class quad_scoreboard;
        quad_t  expected_quads[$];
        longint unsigned width;
        longint old_x, old_y, new_x, new_y;
        longint cur_nx, cur_ny, prev_nx, prev_ny;
        int     seen;
        bit     has_prev;
        int     mismatches;
        int     quads_checked;
        int     deg_quads;
        int     sat_quads;

        function new();
            width = HW_RESET;
            mismatches = 0;
            quads_checked = 0;
            deg_quads = 0;
            sat_quads = 0;
            clear_line();
        endfunction

        function void clear_line();
            old_x = 0; old_y = 0; new_x = 0; new_y = 0;
            cur_nx = 0; cur_ny = 0; prev_nx = 0; prev_ny = 0;
            seen = 0;
            has_prev = 0;
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint unsigned magn(longint a);
            return (a < 0) ? longint'(-a) : longint'(a);
        endfunction

        function void segment_normal(longint dx, longint dy, output longint nx,
                                     output longint ny);
            longint a, b;
            longint unsigned ua, ub, r;
            a = dy;
            b = -dx;
            ua = magn(a);
            ub = magn(b);
            while (ua >= (64'd1 << 20) || ub >= (64'd1 << 20)) begin
                ua = ua >> 1;
                ub = ub >> 1;
            end
            if (ua == 0 && ub == 0) begin
                nx = 0;
                ny = 0;
                return;
            end
            r = floor_root((ua * ua + ub * ub) << 20);
            nx = longint'(((ua << 25) + r) / (2 * r));
            ny = longint'(((ub << 25) + r) / (2 * r));
            if (a < 0) nx = -nx;
            if (b < 0) ny = -ny;
        endfunction

        function bit scaled_offset(longint sx, longint sy, output longint ox,
                                   output longint oy);
            longint unsigned ux, uy, r;
            ux = magn(sx);
            uy = magn(sy);
            if (ux == 0 && uy == 0) begin
                ox = 0;
                oy = 0;
                return 1;
            end
            r = floor_root((ux * ux + uy * uy) << 20);
            ox = longint'((((ux * width) << 11) + r) / (2 * r));
            oy = longint'((((uy * width) << 11) + r) / (2 * r));
            if (sx < 0) ox = -ox;
            if (sy < 0) oy = -oy;
            return 0;
        endfunction

        function bit joint_offset(longint ax, longint ay, bit pair, longint bx,
                                  longint by, output longint ox, output longint oy);
            if (pair && ((ax == 0 && ay == 0) || (bx == 0 && by == 0))) begin
                ox = 0;
                oy = 0;
                return 1;
            end
            if (!pair) return scaled_offset(ax, ay, ox, oy);
            return scaled_offset(ax + bx, ay + by, ox, oy);
        endfunction

        function logic signed [CW-1:0] clamp(longint v, longint o, inout bit sat);
            longint c;
            c = v + o;
            if (c > CMAX) begin c = CMAX; sat = 1; end
            if (c < CMIN) begin c = CMIN; sat = 1; end
            return c[CW-1:0];
        endfunction

        function void push_quad(longint ox1, longint oy1, longint ox2, longint oy2,
                                bit fin, bit deg);
            quad_t q;
            bit sat;
            sat = 0;
            q.c0x = clamp(old_x, ox1, sat);
            q.c0y = clamp(old_y, oy1, sat);
            q.c1x = clamp(old_x, -ox1, sat);
            q.c1y = clamp(old_y, -oy1, sat);
            q.c2x = clamp(new_x, -ox2, sat);
            q.c2y = clamp(new_y, -oy2, sat);
            q.c3x = clamp(new_x, ox2, sat);
            q.c3y = clamp(new_y, oy2, sat);
            q.fin = fin;
            q.deg = deg;
            q.sat = sat;
            expected_quads = {expected_quads, q};
        endfunction

        function void note_point(logic signed [CW-1:0] px_in,
                                 logic signed [CW-1:0] py_in, bit last);
            longint px, py, nx, ny, ax, ay, bx, by;
            bit d;
            px = px_in;
            py = py_in;
            if (seen == 0) begin
                new_x = px;
                new_y = py;
                seen = 1;
                if (last) clear_line();
                return;
            end
            segment_normal(px - new_x, py - new_y, nx, ny);
            if (seen >= 2) begin
                d = joint_offset(cur_nx, cur_ny, has_prev, prev_nx, prev_ny, ax, ay);
                d = joint_offset(cur_nx, cur_ny, 1, nx, ny, bx, by) || d;
                push_quad(ax, ay, bx, by, 0, d);
                prev_nx = cur_nx;
                prev_ny = cur_ny;
                has_prev = 1;
            end else begin
                has_prev = 0;
            end
            old_x = new_x;
            old_y = new_y;
            new_x = px;
            new_y = py;
            cur_nx = nx;
            cur_ny = ny;
            seen = 2;
            if (last) begin
                d = joint_offset(cur_nx, cur_ny, has_prev, prev_nx, prev_ny, ax, ay);
                d = joint_offset(cur_nx, cur_ny, 0, 0, 0, bx, by) || d;
                push_quad(ax, ay, bx, by, 1, d);
                clear_line();
            end
        endfunction

        function void check_quad(quad_t got);
            quad_t want;
            if (expected_quads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("quad with none expected: %h", got);
                return;
            end
            want = expected_quads.pop_front();
            quads_checked++;
            if (want.deg) deg_quads++;
            if (want.sat) sat_quads++;
            if (got.c0x !== want.c0x || got.c0y !== want.c0y ||
                got.c1x !== want.c1x || got.c1y !== want.c1y ||
                got.c2x !== want.c2x || got.c2y !== want.c2y ||
                got.c3x !== want.c3x || got.c3y !== want.c3y ||
                got.fin !== want.fin || got.deg !== want.deg ||
                got.sat !== want.sat) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("quad mismatch #%0d", mismatches);
                    $display("  exp c0 %h %h c1 %h %h c2 %h %h c3 %h %h f%b d%b s%b",
                             want.c0x, want.c0y, want.c1x, want.c1y, want.c2x,
                             want.c2y, want.c3x, want.c3y, want.fin, want.deg, want.sat);
                    $display("  got c0 %h %h c1 %h %h c2 %h %h c3 %h %h f%b d%b s%b",
                             got.c0x, got.c0y, got.c1x, got.c1y, got.c2x,
                             got.c2y, got.c3x, got.c3y, got.fin, got.deg, got.sat);
                end
            end
        endfunction

        function int pending();
            return expected_quads.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    psq_point_if #(.COORD_WIDTH(CW)) pt_if();
    psq_quad_if #(.COORD_WIDTH(CW)) qd_if();
    psq_cfg_if cf_if();

    polyline_stroke_quads #(.COORD_WIDTH(CW)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .point (pt_if),
        .quad  (qd_if),
        .cfg   (cf_if)
    );

    quad_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int points_sent = 0;
    int lines_sent = 0;
    int widths_used = 0;
    longint last_x = 0;
    longint last_y = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        pt_if.valid <= 1'b0;
        pt_if.point_x <= '0;
        pt_if.point_y <= '0;
        pt_if.last_point <= 1'b0;
        cf_if.valid <= 1'b0;
        cf_if.half_width <= '0;
    end

    always @(posedge clk)
    begin
        if (rst_n && qd_if.valid && qd_if.ready)
            sb.check_quad({qd_if.corner0_x, qd_if.corner0_y, qd_if.corner1_x,
                           qd_if.corner1_y, qd_if.corner2_x, qd_if.corner2_y,
                           qd_if.corner3_x, qd_if.corner3_y, qd_if.final_quad,
                           qd_if.degenerate, qd_if.saturated});
        qd_if.ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    task automatic send_point(longint x, longint y, bit last);
        while ($urandom_range(99) < send_idle)
        begin
            pt_if.valid <= 1'b0;
            @(posedge clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.point_x <= x[CW-1:0];
        pt_if.point_y <= y[CW-1:0];
        pt_if.last_point <= last;
        @(posedge clk);
        while (!pt_if.ready) @(posedge clk);
        sb.note_point(x[CW-1:0], y[CW-1:0], last);
        points_sent++;
        if (last) lines_sent++;
        last_x = longint'($signed(x[CW-1:0]));
        last_y = longint'($signed(y[CW-1:0]));
    endtask

    task automatic drain();
        pt_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (END_WAIT) @(posedge clk);
    endtask

    task automatic write_width(logic [15:0] w);
        drain();
        cf_if.valid <= 1'b1;
        cf_if.half_width <= w;
        @(posedge clk);
        while (!cf_if.ready) @(posedge clk);
        cf_if.valid <= 1'b0;
        sb.width = w;
        widths_used++;
    endtask

    function automatic longint pick_coord(longint prev);
        case ($urandom_range(9))
            0: return longint'($signed(24'($urandom)));
            1: return $urandom_range(1) ? CMAX : CMIN;
            2: return prev;
            3: return prev + $signed($urandom_range(8000)) - 4000;
            default: return prev + $signed($urandom_range(600)) - 300;
        endcase
    endfunction

    task automatic random_line();
        int len;
        longint x, y;
        len = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(8, 2);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(19) == 0) begin
                x = longint'($signed(24'($urandom)));
                y = longint'($signed(24'($urandom)));
            end else begin
                x = pick_coord(last_x);
                y = pick_coord(last_y);
            end
            send_point(x, y, i == len - 1);
        end
    endtask

    initial
    begin
        logic [15:0] widths [6];
        int item_goal;
        widths = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0100, 16'h0000, 16'h0000};
        widths[4] = 16'($urandom);
        widths[5] = 16'($urandom);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single point line, then two point line
        send_point(100, 200, 1);
        send_point(0, 0, 0);
        send_point(2560, 0, 1);
        // turning line with a zero-length segment inside
        send_point(0, 0, 0);
        send_point(1000, 0, 0);
        send_point(1000, 0, 0);
        send_point(1000, 1000, 0);
        send_point(0, 1000, 1);
        // reversal cancels the normals
        send_point(-500, 300, 0);
        send_point(500, 300, 0);
        send_point(-500, 300, 1);
        // extremes and saturation
        send_point(CMAX, CMAX, 0);
        send_point(CMIN, CMIN, 0);
        send_point(CMAX, CMIN, 0);
        send_point(CMIN, CMAX, 0);
        send_point(CMIN, CMAX, 1);
        // long segments past the 20-bit reduction
        send_point(-3000000, 12, 0);
        send_point(4000000, -7, 0);
        send_point(4000000, 5000000, 1);
        write_width(16'hFFFF);
        send_point(CMAX - 10, 0, 0);
        send_point(CMAX - 10, 5000, 0);
        send_point(CMIN + 10, 5000, 1);

        for (int ph = 0; ph < 6; ph++)
        begin
            write_width(widths[ph]);
            send_idle = (ph < 2) ? 18 : (ph < 4) ? 71 : 0;
            recv_idle = (ph < 2) ? 71 : (ph < 4) ? 18 : 0;
            item_goal = points_sent + 316;
            while (points_sent < item_goal)
            begin
                random_line();
                if (ph == 2 && points_sent > item_goal - 160 && points_sent < item_goal - 150)
                begin
                    pt_if.valid <= 1'b0;
                    @(posedge clk);
                    while (sb.pending() != 0) @(posedge clk);
                end
            end
        end
        drain();

        $display("covered %0d points in %0d lines under %0d half widths",
                 points_sent, lines_sent, widths_used);
        $display("checked %0d quads, %0d degenerate, %0d saturated",
                 sb.quads_checked, sb.deg_quads, sb.sat_quads);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** polyline_stroke_quads: PASSED **");
        else
            $display("** polyline_stroke_quads: FAILED **");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("timeout with %0d quads outstanding", sb.pending());
        $display("** polyline_stroke_quads: FAILED **");
        $finish;
    end
endmodule
